### hw/rtl/raster_band_threshold_packer_macros.svh
// assertion macros for the raster band threshold packer
`ifndef RASTER_BAND_THRESHOLD_PACKER_MACROS_SVH
`define RASTER_BAND_THRESHOLD_PACKER_MACROS_SVH

// property that must hold at every edge out of reset
`define RBTP_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define RBTP_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/rbtp_pkg.sv
// shared types, constants and microcode table for the raster band threshold packer
package rbtp_pkg;

  localparam int PAGE_WIDTH_DEF       = 832;
  localparam int BAND_BYTE_BUDGET_DEF = 8320;
  localparam int MAX_BAND_ROWS_DEF    = 400;

  localparam int PIXEL_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int WIDTH_W     = 16;
  localparam int HEIGHT_W    = 12;
  localparam int BPR_W       = 14;
  localparam int ROWS_W      = 9;
  localparam int DIV_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [PIXEL_W-1:0]  DOT_LEVEL  = 8'd180;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 12'hfa0;

  // raster header layout
  localparam int HDR_LEN   = 11;
  localparam int HDR_IDX_W = 4;
  localparam logic [HDR_IDX_W-1:0] HPOS_DC2     = 4'd0;
  localparam logic [HDR_IDX_W-1:0] HPOS_EQ      = 4'd1;
  localparam logic [HDR_IDX_W-1:0] HPOS_NUL0    = 4'd2;
  localparam logic [HDR_IDX_W-1:0] HPOS_GS      = 4'd3;
  localparam logic [HDR_IDX_W-1:0] HPOS_V       = 4'd4;
  localparam logic [HDR_IDX_W-1:0] HPOS_ZERO    = 4'd5;
  localparam logic [HDR_IDX_W-1:0] HPOS_MODE    = 4'd6;
  localparam logic [HDR_IDX_W-1:0] HPOS_BPR_LO  = 4'd7;
  localparam logic [HDR_IDX_W-1:0] HPOS_BPR_HI  = 4'd8;
  localparam logic [HDR_IDX_W-1:0] HPOS_ROWS_LO = 4'd9;
  localparam logic [HDR_IDX_W-1:0] HPOS_ROWS_HI = 4'd10;

  localparam logic [BYTE_W-1:0] HDR_DC2  = 8'h12;
  localparam logic [BYTE_W-1:0] HDR_EQ   = 8'h3d;
  localparam logic [BYTE_W-1:0] HDR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] HDR_GS   = 8'h1d;
  localparam logic [BYTE_W-1:0] HDR_V    = 8'h76;
  localparam logic [BYTE_W-1:0] HDR_ZERO = 8'h30;

  // sequencer steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] S_WAIT       = 4'd0;
  localparam logic [STEP_W-1:0] S_CHK_ACTIVE = 4'd1;
  localparam logic [STEP_W-1:0] S_CHK_HEIGHT = 4'd2;
  localparam logic [STEP_W-1:0] S_START      = 4'd3;
  localparam logic [STEP_W-1:0] S_DIV_WAIT   = 4'd4;
  localparam logic [STEP_W-1:0] S_LOAD_RPB   = 4'd5;
  localparam logic [STEP_W-1:0] S_HDR_CHK    = 4'd6;
  localparam logic [STEP_W-1:0] S_HDR_EMIT   = 4'd7;
  localparam logic [STEP_W-1:0] S_PIX        = 4'd8;
  localparam logic [STEP_W-1:0] S_DATA       = 4'd9;
  localparam logic [STEP_W-1:0] S_ROW        = 4'd10;

  // datapath actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_TAKE     = 3'd1;
  localparam logic [2:0] ACT_START    = 3'd2;
  localparam logic [2:0] ACT_LOAD_RPB = 3'd3;
  localparam logic [2:0] ACT_HDR      = 3'd4;
  localparam logic [2:0] ACT_PIX      = 3'd5;
  localparam logic [2:0] ACT_DATA     = 3'd6;
  localparam logic [2:0] ACT_ROW      = 3'd7;

  // jump conditions
  localparam logic [3:0] C_NEVER       = 4'd0;
  localparam logic [3:0] C_ALWAYS      = 4'd1;
  localparam logic [3:0] C_NO_PIXEL    = 4'd2;
  localparam logic [3:0] C_ACTIVE      = 4'd3;
  localparam logic [3:0] C_HEIGHT_ZERO = 4'd4;
  localparam logic [3:0] C_DIV_BUSY    = 4'd5;
  localparam logic [3:0] C_NO_HEADER   = 4'd6;
  localparam logic [3:0] C_HDR_PENDING = 4'd7;
  localparam logic [3:0] C_DATA_WAIT   = 4'd8;

  typedef struct packed {
    logic [2:0]        act;
    logic [3:0]        cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
    uword_t w;
    unique case (addr)
      S_WAIT:       w = '{ACT_TAKE,     C_NO_PIXEL,    S_WAIT};
      S_CHK_ACTIVE: w = '{ACT_NONE,     C_ACTIVE,      S_HDR_CHK};
      S_CHK_HEIGHT: w = '{ACT_NONE,     C_HEIGHT_ZERO, S_WAIT};
      S_START:      w = '{ACT_START,    C_NEVER,       S_WAIT};
      S_DIV_WAIT:   w = '{ACT_NONE,     C_DIV_BUSY,    S_DIV_WAIT};
      S_LOAD_RPB:   w = '{ACT_LOAD_RPB, C_NEVER,       S_WAIT};
      S_HDR_CHK:    w = '{ACT_NONE,     C_NO_HEADER,   S_PIX};
      S_HDR_EMIT:   w = '{ACT_HDR,      C_HDR_PENDING, S_HDR_EMIT};
      S_PIX:        w = '{ACT_PIX,      C_NEVER,       S_WAIT};
      S_DATA:       w = '{ACT_DATA,     C_DATA_WAIT,   S_DATA};
      S_ROW:        w = '{ACT_ROW,      C_ALWAYS,      S_WAIT};
      default:      w = '{ACT_NONE,     C_ALWAYS,      S_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                                 input logic [BPR_W-1:0]     bpr,
                                                 input logic [ROWS_W-1:0]    band);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      HPOS_DC2:     b = HDR_DC2;
      HPOS_EQ:      b = HDR_EQ;
      HPOS_NUL0:    b = HDR_NUL;
      HPOS_GS:      b = HDR_GS;
      HPOS_V:       b = HDR_V;
      HPOS_ZERO:    b = HDR_ZERO;
      HPOS_MODE:    b = HDR_NUL;
      HPOS_BPR_LO:  b = bpr[7:0];
      HPOS_BPR_HI:  b = {2'b00, bpr[BPR_W-1:8]};
      HPOS_ROWS_LO: b = band[7:0];
      HPOS_ROWS_HI: b = {7'b0000000, band[ROWS_W-1]};
      default:      b = HDR_NUL;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/rbtp_div.sv
// bit-serial restoring divider: band byte budget over bytes per row
module rbtp_div #(
  parameter int BAND_BYTE_BUDGET = rbtp_pkg::BAND_BYTE_BUDGET_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rbtp_pkg::BPR_W-1:0]  divisor,
  output logic                        busy,
  output logic [rbtp_pkg::DIV_W-1:0]  quotient
);
  import rbtp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] num;
  logic [DIV_W-1:0] rem;
  logic [BPR_W-1:0] dvs;
  logic [DIV_W:0]   rem_shift;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign rem_shift = {rem, num[DIV_W-1]};
  assign diff      = rem_shift - (DIV_W+1)'(dvs);
  assign ge        = rem_shift >= (DIV_W+1)'(dvs);
  assign quotient  = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      num  <= DIV_W'(BAND_BYTE_BUDGET);
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
      num <= {num[DIV_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/raster_band_threshold_packer.sv
// top level of the raster band threshold packer
// Takes 8-bit gray pixels, row-major with the image's last row first, and
// emits a printer byte stream: an 11-byte raster header before each band,
// then dot bytes packed lsb first, one bit per column (dot when gray < 180).
// Channels: pixel (pixel_valid / pixel_stall) in, out_byte with last_of_run
// (out_valid / out_stall) out; an item moves when valid is high and stall low.
// Config: cfg_valid / cfg_ready with cfg_index (0 width, 1 height), cfg_data;
// write only while idle, values are latched when the next image starts.
// Sequencing: a small microcoded sequencer runs each pixel through six steps
// (take, active check, header check, pixel, data, row); the data step loads
// a finished byte into the output register. A band's first pixel also runs
// the header steps that emit the 11-byte header; an image's first pixel the
// start steps that wait on the bit-serial divider that sizes the bands.
// Every emitted byte also waits for the one-entry output register to drain.
// Stall: while out_stall holds, the output register keeps its beat and the
// sequencer waits at its next emit step; pixel_stall stays high meanwhile.
// Reset: synchronous; clears the sequencer, drops the current image and loads
// width 832, height 1.
`include "raster_band_threshold_packer_macros.svh"

module raster_band_threshold_packer #(
  parameter int PAGE_WIDTH       = rbtp_pkg::PAGE_WIDTH_DEF,
  parameter int BAND_BYTE_BUDGET = rbtp_pkg::BAND_BYTE_BUDGET_DEF,
  parameter int MAX_BAND_ROWS    = rbtp_pkg::MAX_BAND_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [rbtp_pkg::PIXEL_W-1:0]     pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rbtp_pkg::BYTE_W-1:0]      out_byte,
  output logic                             last_of_run,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rbtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rbtp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rbtp_pkg::*;

  logic [WIDTH_W-1:0]   image_width;
  logic [HEIGHT_W-1:0]  image_height;
  logic [STEP_W-1:0]    step;
  logic [STEP_W-1:0]    step_next;
  logic                 active;
  logic                 reject;
  logic [WIDTH_W-1:0]   row_width;
  logic [WIDTH_W-1:0]   column_count;
  logic [ROWS_W-1:0]    band_row_count;
  logic [HEIGHT_W-1:0]  rows_remaining;
  logic [BYTE_W-1:0]    dot_accumulator;
  logic [ROWS_W-1:0]    rows_per_band;
  logic [BPR_W-1:0]     bytes_per_row;
  logic [PIXEL_W-1:0]   pix;
  logic [HDR_IDX_W-1:0] hdr_idx;

  uword_t               uw;
  logic                 jump;
  logic                 slot_free;
  logic                 emit;
  logic [WIDTH_W-1:0]   col_inc;
  logic                 done_pre;
  logic                 done_post;
  logic                 need_header;
  logic                 hdr_last;
  logic [ROWS_W-1:0]    band;
  logic [WIDTH_W-1:0]   width_eff;
  logic [BPR_W-1:0]     bpr_calc;
  logic [ROWS_W-1:0]    rpb_clamp;
  logic [HEIGHT_W-1:0]  rows_rem_dec;
  logic [ROWS_W-1:0]    brc_inc;
  logic                 div_busy;
  logic [DIV_W-1:0]     div_quotient;
  logic                 at_wait;
  logic                 band_sized;

  assign uw          = ucode_rom(step);
  assign pixel_stall = rst || (step != S_WAIT);
  assign cfg_ready   = !rst;
  assign slot_free   = !out_valid || !out_stall;

  assign col_inc     = column_count + WIDTH_W'(1);
  assign done_pre    = (col_inc[2:0] == 3'd0) || (col_inc >= row_width);
  assign done_post   = (column_count[2:0] == 3'd0) || (column_count >= row_width);
  assign need_header = !reject && (column_count == '0) && (band_row_count == '0);
  assign hdr_last    = hdr_idx == HDR_IDX_W'(HDR_LEN - 1);
  assign band        = (rows_remaining < HEIGHT_W'(rows_per_band)) ?
                       rows_remaining[ROWS_W-1:0] : rows_per_band;
  assign emit        = slot_free && ((uw.act == ACT_HDR) ||
                       ((uw.act == ACT_DATA) && done_post && !reject));

  assign width_eff   = (image_width == '0) ? WIDTH_W'(1) : image_width;
  assign bpr_calc    = BPR_W'(((WIDTH_W+1)'(width_eff) + (WIDTH_W+1)'(7)) >> 3);
  assign rpb_clamp   = (div_quotient > DIV_W'(MAX_BAND_ROWS)) ? ROWS_W'(MAX_BAND_ROWS) :
                       (div_quotient == '0) ? ROWS_W'(1) : div_quotient[ROWS_W-1:0];
  assign rows_rem_dec = (rows_remaining != '0) ? rows_remaining - HEIGHT_W'(1) : '0;
  assign brc_inc      = band_row_count + ROWS_W'(1);

  assign at_wait    = (step == S_WAIT) && active;
  assign band_sized = (rows_per_band != '0) && (bytes_per_row != '0);

  rbtp_div #(
    .BAND_BYTE_BUDGET(BAND_BYTE_BUDGET)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (uw.act == ACT_START),
    .divisor  (bpr_calc),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_comb begin
    unique case (uw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_PIXEL:    jump = !pixel_valid;
      C_ACTIVE:      jump = active;
      C_HEIGHT_ZERO: jump = image_height == '0;
      C_DIV_BUSY:    jump = div_busy;
      C_NO_HEADER:   jump = !need_header;
      C_HDR_PENDING: jump = !(slot_free && hdr_last);
      C_DATA_WAIT:   jump = done_post && !reject && !slot_free;
      default:       jump = 1'b0;
    endcase
    step_next = jump ? uw.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_W'(832);
      image_height    <= HEIGHT_W'(1);
      step            <= S_WAIT;
      active          <= 1'b0;
      reject          <= 1'b0;
      row_width       <= '0;
      column_count    <= '0;
      band_row_count  <= '0;
      rows_remaining  <= '0;
      dot_accumulator <= '0;
      rows_per_band   <= '0;
      bytes_per_row   <= '0;
      hdr_idx         <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WIDTH:  image_width  <= cfg_data;
          CFG_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
          default:    ;
        endcase
      end

      step <= step_next;

      // a new beat may load in the cycle the old one leaves
      out_valid <= emit || (out_valid && out_stall);

      case (uw.act)
        ACT_TAKE: begin
          if (pixel_valid) begin
            pix <= pixel;
          end
        end
        ACT_START: begin
          row_width       <= width_eff;
          bytes_per_row   <= bpr_calc;
          rows_remaining  <= image_height;
          reject          <= image_height > MAX_HEIGHT;
          column_count    <= '0;
          band_row_count  <= '0;
          dot_accumulator <= '0;
          active          <= 1'b1;
        end
        ACT_LOAD_RPB: begin
          rows_per_band <= rpb_clamp;
        end
        ACT_HDR: begin
          if (slot_free) begin
            out_byte    <= hdr_byte(hdr_idx, bytes_per_row, band);
            last_of_run <= hdr_last && !done_pre;
            hdr_idx     <= hdr_last ? '0 : hdr_idx + HDR_IDX_W'(1);
          end
        end
        ACT_PIX: begin
          if ((column_count < WIDTH_W'(PAGE_WIDTH)) && (pix < DOT_LEVEL)) begin
            dot_accumulator[column_count[2:0]] <= 1'b1;
          end
          column_count <= col_inc;
        end
        ACT_DATA: begin
          if (done_post) begin
            if (reject) begin
              dot_accumulator <= '0;
            end else if (slot_free) begin
              out_byte        <= dot_accumulator;
              last_of_run     <= 1'b1;
              dot_accumulator <= '0;
            end
          end
        end
        ACT_ROW: begin
          if (column_count >= row_width) begin
            column_count   <= '0;
            rows_remaining <= rows_rem_dec;
            if ((brc_inc >= rows_per_band) || (rows_rem_dec == '0)) begin
              band_row_count <= '0;
            end else begin
              band_row_count <= brc_inc;
            end
            if (rows_rem_dec == '0) begin
              active <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `RBTP_ALWAYS(a_hdr_idx_range, hdr_idx < HDR_IDX_W'(HDR_LEN), "header index past end")
  `RBTP_IMPLY(a_hdr_sized, step == S_HDR_EMIT, band_sized, "header before band sizing")
  `RBTP_IMPLY(a_div_done, step == S_LOAD_RPB, !div_busy, "band size taken while divider busy")
  `RBTP_IMPLY(a_col_in_row, at_wait, column_count < row_width, "column past row end")
  `RBTP_IMPLY(a_band_row_in_range, at_wait, band_row_count < rows_per_band, "band row past band")

endmodule
